// File: design/line_buffer_2d_convolution_unit_assert.svh
// Assertion macros used by the line buffer convolution queue.
`ifndef LINE_BUFFER_2D_CONVOLUTION_UNIT_ASSERT_SVH
`define LINE_BUFFER_2D_CONVOLUTION_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define LBC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Next-cycle implication.
`define LBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`else

`define LBC_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define LBC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: design/lbc_pkg.sv
// Shared types, widths and register codes for the line buffer convolution unit.
package lbc_pkg;

  localparam int PIX_W       = 8;
  localparam int DIM_W       = 11;
  localparam int SHIFT_W     = 5;
  localparam int WORD_W      = 64;
  localparam int TAP_W       = 8;
  localparam int OUT_W       = 21;
  localparam int ADDR_W      = 3;
  localparam int DIM_CMP_W   = 13;  // holds any clamped dimension up to 4096
  localparam int PROD_W      = 17;  // unsigned pixel times signed tap
  localparam int ACC_W       = 33;  // sum plus rounding bias for shifts up to 31
  localparam int QUEUE_DEPTH = 4;

  localparam int DEF_WIN_DIM  = 3;
  localparam int DEF_MAX_LINE = 1024;
  localparam int DEF_MAX_ROWS = 1024;

  // Register indexes
  localparam logic [ADDR_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [ADDR_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [ADDR_W-1:0] REG_SHIFT_AMOUNT = 3'd2;
  localparam logic [ADDR_W-1:0] REG_TAPS_WORD_A  = 3'd3;
  localparam logic [ADDR_W-1:0] REG_TAPS_WORD_B  = 3'd4;
  localparam logic [ADDR_W-1:0] REG_TAPS_WORD_C  = 3'd5;
  localparam logic [ADDR_W-1:0] REG_TAP_LAST     = 3'd6;

  // Register reset values
  localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 11'd1024;
  localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 11'd1024;

  // Frame dimensions handed to the front end
  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } lbc_dims_t;

  // Per-pixel classification carried through the queue
  typedef struct packed {
    logic produce;
    logic last;
  } lbc_flags_t;

endpackage

// File: design/lbc_pixel_if.sv
// Pixel input channel.
interface lbc_pixel_if;
  logic                      valid;
  logic                      ready;
  logic [lbc_pkg::PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

// File: design/lbc_result_if.sv
// Filtered result output channel.
interface lbc_result_if;
  logic                             valid;
  logic                             ready;
  logic signed [lbc_pkg::OUT_W-1:0] filtered_value;
  logic                             frame_last;

  modport source (output valid, output filtered_value, output frame_last, input ready);
  modport sink   (input valid, input filtered_value, input frame_last, output ready);
endinterface

// File: design/lbc_cfg_if.sv
// Configuration register write channel.
interface lbc_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [lbc_pkg::ADDR_W-1:0] addr;
  logic [lbc_pkg::WORD_W-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

// File: design/lbc_front.sv
// Front end: raster counters, line store access and pixel classification.
module lbc_front #(
  parameter int WIN_DIM  = lbc_pkg::DEF_WIN_DIM,
  parameter int MAX_LINE = lbc_pkg::DEF_MAX_LINE,
  parameter int MAX_ROWS = lbc_pkg::DEF_MAX_ROWS
) (
  input  logic                              clk,
  input  logic                              rst,
  lbc_pixel_if.sink                         pixels,
  input  lbc_pkg::lbc_dims_t                dims,
  output logic                              q_push,
  output logic [WIN_DIM*lbc_pkg::PIX_W-1:0] q_column,
  output lbc_pkg::lbc_flags_t               q_flags,
  input  logic                              q_full
);
  import lbc_pkg::*;

  localparam int KM1 = WIN_DIM - 1;
  localparam int LW  = KM1 * PIX_W;
  localparam int CW  = $clog2(MAX_LINE);
  localparam int RW  = $clog2(MAX_ROWS);
  localparam int DW  = DIM_CMP_W;

  // Line store: one word per column, one lane per stored line
  logic [LW-1:0] mem [MAX_LINE];

  logic [CW-1:0]    col_count;
  logic [RW-1:0]    row_count;
  logic [DW-1:0]    w_eff;
  logic [DW-1:0]    h_eff;
  logic [CW-1:0]    col_cur;
  logic [RW-1:0]    row_cur;
  logic             col_end;
  logic             row_end;
  logic [CW-1:0]    col_count_next;
  logic [RW-1:0]    row_count_next;
  logic             accept;
  lbc_flags_t       flags_cur;

  logic             s1_valid;
  logic [PIX_W-1:0] s1_pixel;
  logic [CW-1:0]    s1_col;
  lbc_flags_t       s1_flags;
  logic             s1_fire;
  logic [LW-1:0]    mem_q;
  logic             fwd_hit;
  logic [LW-1:0]    fwd_data;
  logic [LW-1:0]    above;
  logic [LW-1:0]    wr_data;

  // Clamp the configured frame size
  always_comb begin
    if (dims.width == '0) begin
      w_eff = DW'(1);
    end else if (DW'(dims.width) > DW'(MAX_LINE)) begin
      w_eff = DW'(MAX_LINE);
    end else begin
      w_eff = DW'(dims.width);
    end
    if (dims.height == '0) begin
      h_eff = DW'(1);
    end else if (DW'(dims.height) > DW'(MAX_ROWS)) begin
      h_eff = DW'(MAX_ROWS);
    end else begin
      h_eff = DW'(dims.height);
    end
  end

  // Position of the arriving pixel and the next counter values
  always_comb begin
    col_cur = (DW'(col_count) >= w_eff) ? '0 : col_count;
    row_cur = (DW'(row_count) >= h_eff) ? '0 : row_count;
    col_end = (DW'(col_cur) + DW'(1)) >= w_eff;
    row_end = (DW'(row_cur) + DW'(1)) >= h_eff;
    if (col_end) begin
      col_count_next = '0;
      row_count_next = row_end ? '0 : row_cur + RW'(1);
    end else begin
      col_count_next = col_cur + CW'(1);
      row_count_next = row_cur;
    end
    flags_cur.produce = (w_eff >= DW'(WIN_DIM)) && (h_eff >= DW'(WIN_DIM)) &&
                        (DW'(row_cur) >= DW'(KM1)) && (DW'(col_cur) >= DW'(KM1));
    flags_cur.last    = (DW'(row_cur) == h_eff - DW'(1)) && (DW'(col_cur) == w_eff - DW'(1));
  end

  assign s1_fire      = s1_valid && !q_full;
  assign pixels.ready = !s1_valid || !q_full;
  assign accept       = pixels.valid && pixels.ready;

  // Column above the pixel, with bypass of a write to the same column
  assign above = fwd_hit ? fwd_data : mem_q;

  // Lines move up by one; the newest line takes the pixel
  always_comb begin
    for (int r = 0; r < KM1 - 1; r++) begin
      wr_data[r*PIX_W +: PIX_W] = above[(r+1)*PIX_W +: PIX_W];
    end
    wr_data[(KM1-1)*PIX_W +: PIX_W] = s1_pixel;
  end

  assign q_push   = s1_fire;
  assign q_column = {s1_pixel, above};
  assign q_flags  = s1_flags;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      s1_valid  <= 1'b0;
      fwd_hit   <= 1'b0;
    end else begin
      if (accept) begin
        col_count <= col_count_next;
        row_count <= row_count_next;
        s1_valid  <= 1'b1;
        fwd_hit   <= s1_fire && (s1_col == col_cur);
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // Payload and line store
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel <= pixels.pixel_in;
      s1_col   <= col_cur;
      s1_flags <= flags_cur;
      fwd_data <= wr_data;
      mem_q    <= mem[col_cur];
    end
    if (s1_fire) begin
      mem[s1_col] <= wr_data;
    end
  end

endmodule

// File: design/lbc_queue.sv
// Short queue between the front end and the arithmetic back end.
`include "line_buffer_2d_convolution_unit_assert.svh"

module lbc_queue #(
  parameter int WIDTH = 2,
  parameter int DEPTH = lbc_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  import lbc_pkg::*;

  localparam int PW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign dout  = slots[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  `LBC_ASSERT_IMPLIES(a_no_overflow, clk, rst, full, !push)
  `LBC_ASSERT_IMPLIES(a_no_underflow, clk, rst, empty, !pop)
  `LBC_ASSERT_NEXT(a_count_up, clk, rst, push && !pop, count == $past(count) + CNT_W'(1))
  `LBC_ASSERT_NEXT(a_count_down, clk, rst, pop && !push, count == $past(count) - CNT_W'(1))

endmodule

// File: design/lbc_back.sv
// Back end: sliding window, tap products, adder tree, rounding shift and output register.
module lbc_back #(
  parameter int WIN_DIM = lbc_pkg::DEF_WIN_DIM
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      q_empty,
  input  logic [WIN_DIM*lbc_pkg::PIX_W-1:0]         q_column,
  input  lbc_pkg::lbc_flags_t                       q_flags,
  output logic                                      q_pop,
  input  logic [WIN_DIM*WIN_DIM*lbc_pkg::TAP_W-1:0] taps,
  input  logic [lbc_pkg::SHIFT_W-1:0]               shift_amount,
  lbc_result_if.source                              results
);
  import lbc_pkg::*;

  localparam int KK    = WIN_DIM * WIN_DIM;
  localparam int ROW_W = PROD_W + $clog2(WIN_DIM);
  localparam int SUM_W = ROW_W + $clog2(WIN_DIM);

  logic                     adv;
  logic [PIX_W-1:0]         win [KK];
  logic                     b1_valid, b2_valid, b3_valid, b4_valid, o_valid;
  logic                     b1_last, b2_last, b3_last, b4_last;
  logic signed [PROD_W-1:0] prod [KK];
  logic signed [ROW_W-1:0]  row_sum [WIN_DIM];
  logic signed [ROW_W-1:0]  row_sum_next [WIN_DIM];
  logic signed [SUM_W-1:0]  total;
  logic signed [SUM_W-1:0]  total_next;
  logic signed [ACC_W-1:0]  bias;
  logic signed [ACC_W-1:0]  biased;
  logic signed [ACC_W-1:0]  shifted;

  // The whole pipe moves when the output register can take a value
  assign adv   = !o_valid || results.ready;
  assign q_pop = adv && !q_empty;

  // Window shifts left one column per dequeued pixel
  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int r = 0; r < WIN_DIM; r++) begin
        for (int c = 0; c < WIN_DIM - 1; c++) begin
          win[r*WIN_DIM + c] <= win[r*WIN_DIM + c + 1];
        end
        win[r*WIN_DIM + WIN_DIM - 1] <= q_column[r*PIX_W +: PIX_W];
      end
    end
  end

  // Row partial sums
  always_comb begin
    for (int r = 0; r < WIN_DIM; r++) begin
      row_sum_next[r] = '0;
      for (int c = 0; c < WIN_DIM; c++) begin
        row_sum_next[r] = row_sum_next[r] + ROW_W'(prod[r*WIN_DIM + c]);
      end
    end
  end

  // Final sum over rows
  always_comb begin
    total_next = '0;
    for (int r = 0; r < WIN_DIM; r++) begin
      total_next = total_next + SUM_W'(row_sum[r]);
    end
  end

  // Round half up, then arithmetic shift
  always_comb begin
    bias    = (shift_amount == '0) ? '0 :
              (ACC_W'(1) << (shift_amount - SHIFT_W'(1)));
    biased  = ACC_W'(total) + bias;
    shifted = biased >>> shift_amount;
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
      b2_valid <= 1'b0;
      b3_valid <= 1'b0;
      b4_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else if (adv) begin
      b1_valid <= q_pop && q_flags.produce;
      b2_valid <= b1_valid;
      b3_valid <= b2_valid;
      b4_valid <= b3_valid;
      o_valid  <= b4_valid;
    end
  end

  // Arithmetic datapath and frame-end tags
  always_ff @(posedge clk) begin
    if (adv) begin
      b1_last <= q_flags.last;
      b2_last <= b1_last;
      b3_last <= b2_last;
      b4_last <= b3_last;
      for (int k = 0; k < KK; k++) begin
        prod[k] <= PROD_W'($signed({1'b0, win[k]})) *
                   PROD_W'($signed(taps[k*TAP_W +: TAP_W]));
      end
      for (int r = 0; r < WIN_DIM; r++) begin
        row_sum[r] <= row_sum_next[r];
      end
      total                  <= total_next;
      results.filtered_value <= shifted[OUT_W-1:0];
      results.frame_last     <= b4_last;
    end
  end

  assign results.valid = o_valid;

endmodule

// File: design/line_buffer_2d_convolution_unit.sv
// Streaming KxK convolution over raster pixels using K-1 line stores.
// Throughput: one pixel per cycle unless the result side stalls; the line store is read and
// written once per pixel. A result passes the front stage, queue, window, products, row
// sums and total, then the rounding shift into the output register.
// Reset (rst, synchronous): counters, queue and pipe valids clear, registers take
// their reset values; line store and window are not cleared and need no clearing pass.
module line_buffer_2d_convolution_unit #(
  parameter int WIN_DIM  = lbc_pkg::DEF_WIN_DIM,
  parameter int MAX_LINE = lbc_pkg::DEF_MAX_LINE,
  parameter int MAX_ROWS = lbc_pkg::DEF_MAX_ROWS
) (
  input  logic         clk,
  input  logic         rst,
  lbc_pixel_if.sink    pixels,
  lbc_result_if.source results,
  lbc_cfg_if.sink      cfg
);
  import lbc_pkg::*;

  localparam int KK = WIN_DIM * WIN_DIM;
  localparam int QW = WIN_DIM * PIX_W + $bits(lbc_flags_t);

  logic [DIM_W-1:0]    frame_width;
  logic [DIM_W-1:0]    frame_height;
  logic [SHIFT_W-1:0]  shift_amount;
  logic [WORD_W-1:0]   taps_word_a;
  logic [WORD_W-1:0]   taps_word_b;
  logic [WORD_W-1:0]   taps_word_c;
  logic [TAP_W-1:0]    tap_last;
  logic [KK*TAP_W-1:0] taps;
  lbc_dims_t           dims;

  logic                     q_push;
  logic                     q_pop;
  logic                     q_full;
  logic                     q_empty;
  logic [WIN_DIM*PIX_W-1:0] f_column;
  lbc_flags_t               f_flags;
  logic [QW-1:0]            q_out;
  logic [WIN_DIM*PIX_W-1:0] b_column;
  lbc_flags_t               b_flags;

  assign cfg.ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RST_FRAME_WIDTH;
      frame_height <= RST_FRAME_HEIGHT;
      shift_amount <= '0;
      taps_word_a  <= '0;
      taps_word_b  <= '0;
      taps_word_c  <= '0;
      tap_last     <= '0;
    end else if (cfg.valid) begin
      case (cfg.addr)
        REG_FRAME_WIDTH:  frame_width  <= cfg.data[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg.data[DIM_W-1:0];
        REG_SHIFT_AMOUNT: shift_amount <= cfg.data[SHIFT_W-1:0];
        REG_TAPS_WORD_A:  taps_word_a  <= cfg.data;
        REG_TAPS_WORD_B:  taps_word_b  <= cfg.data;
        REG_TAPS_WORD_C:  taps_word_c  <= cfg.data;
        REG_TAP_LAST:     tap_last     <= cfg.data[TAP_W-1:0];
        default: ;
      endcase
    end
  end

  assign dims.width  = frame_width;
  assign dims.height = frame_height;

  // Row-major tap vector from the packed tap words
  for (genvar k = 0; k < KK; k++) begin : g_tap
    if (k < 8) begin : g_a
      assign taps[k*TAP_W +: TAP_W] = taps_word_a[k*TAP_W +: TAP_W];
    end else if (k < 16) begin : g_b
      assign taps[k*TAP_W +: TAP_W] = taps_word_b[(k-8)*TAP_W +: TAP_W];
    end else if (k < 24) begin : g_c
      assign taps[k*TAP_W +: TAP_W] = taps_word_c[(k-16)*TAP_W +: TAP_W];
    end else begin : g_l
      assign taps[k*TAP_W +: TAP_W] = tap_last;
    end
  end

  lbc_front #(
    .WIN_DIM  (WIN_DIM),
    .MAX_LINE (MAX_LINE),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .pixels   (pixels),
    .dims     (dims),
    .q_push   (q_push),
    .q_column (f_column),
    .q_flags  (f_flags),
    .q_full   (q_full)
  );

  lbc_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   ({f_flags, f_column}),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .empty (q_empty)
  );

  assign b_column = q_out[WIN_DIM*PIX_W-1:0];
  assign b_flags  = q_out[QW-1:WIN_DIM*PIX_W];

  lbc_back #(
    .WIN_DIM (WIN_DIM)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_column     (b_column),
    .q_flags      (b_flags),
    .q_pop        (q_pop),
    .taps         (taps),
    .shift_amount (shift_amount),
    .results      (results)
  );

endmodule

// File: tb/line_buffer_2d_convolution_unit_tb.sv
// Self-checking testbench for the streaming 3x3 line buffer convolution unit.
module line_buffer_2d_convolution_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lbc_pkg::*;

  localparam int KSIZE         = DEF_WIN_DIM;
  localparam int KM1           = KSIZE - 1;
  localparam int LINE_MAX      = DEF_MAX_LINE;
  localparam int ROWS_MAX      = DEF_MAX_ROWS;
  localparam int RANDOM_ITEMS  = 550;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 12;   // lets the pipe empty, with margin
  localparam int HOLD_CYCLES   = 300;
  localparam int MAX_REPORTS   = 200;

  // Address with no register behind it; writes must be ignored
  localparam logic [ADDR_W-1:0] REG_UNMAPPED = 3'd7;

  typedef enum int {PIX_UNIFORM, PIX_EXTREME, PIX_NEAR_RAILS} pixel_mode_t;
  typedef enum int {TAPS_RANDOM, TAPS_MAX, TAPS_MIN, TAPS_SMALL} tap_style_t;
  typedef enum int {SHAPE_KEEP, SHAPE_RANDOM, SHAPE_SHRINK, SHAPE_PRESSURE} shape_mode_t;
  typedef enum int {PH_FRAMES, PH_MID_FRAME, PH_PRESSURE, PH_STEADY} phase_kind_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] value;
    logic                    last;
  } conv_result_t;

  // Convolution predictor plus queue of pending filtered values
  class conv_scoreboard;
    logic [DIM_W-1:0]        width_reg;
    logic [DIM_W-1:0]        height_reg;
    logic [SHIFT_W-1:0]      shift_reg;
    logic [WORD_W-1:0]       taps_a;
    logic [WORD_W-1:0]       taps_b;
    logic [WORD_W-1:0]       taps_c;
    logic signed [TAP_W-1:0] tap_24;
    logic [PIX_W-1:0]        line_mem [KM1][LINE_MAX];
    logic [PIX_W-1:0]        win [KSIZE][KSIZE];
    int unsigned             row_cnt;
    int unsigned             col_cnt;
    conv_result_t            expected_results[$];
    int unsigned             failures;

    function new();
      width_reg  = RST_FRAME_WIDTH;
      height_reg = RST_FRAME_HEIGHT;
      shift_reg  = '0;
      taps_a     = '0;
      taps_b     = '0;
      taps_c     = '0;
      tap_24     = '0;
      row_cnt    = 0;
      col_cnt    = 0;
      failures   = 0;
      foreach (line_mem[r, c]) line_mem[r][c] = '0;
      foreach (win[r, c]) win[r][c] = '0;
    endfunction

    // zero acts as one, oversize clamps to the build limit
    function int unsigned clamp_dim(int unsigned v, int unsigned top);
      if (v == 0) return 1;
      return (v > top) ? top : v;
    endfunction

    function int unsigned line_width();
      return clamp_dim(width_reg, LINE_MAX);
    endfunction

    function int unsigned frame_rows();
      return clamp_dim(height_reg, ROWS_MAX);
    endfunction

    function bit makes_results();
      return line_width() >= KSIZE && frame_rows() >= KSIZE;
    endfunction

    function bit at_frame_start();
      return row_cnt == 0 && col_cnt == 0;
    endfunction

    // row-major tap k, signed byte from the packed tap words
    function int tap_at(int unsigned k);
      logic [WORD_W-1:0] word;
      if (k >= 24) return tap_24;
      word = (k < 8) ? taps_a : (k < 16) ? taps_b : taps_c;
      return $signed(word[8*(k%8) +: 8]);
    endfunction

    function void set_register(logic [ADDR_W-1:0] idx, logic [WORD_W-1:0] data);
      case (idx)
        REG_FRAME_WIDTH:  width_reg  = data[DIM_W-1:0];
        REG_FRAME_HEIGHT: height_reg = data[DIM_W-1:0];
        REG_SHIFT_AMOUNT: shift_reg  = data[SHIFT_W-1:0];
        REG_TAPS_WORD_A:  taps_a     = data;
        REG_TAPS_WORD_B:  taps_b     = data;
        REG_TAPS_WORD_C:  taps_c     = data;
        REG_TAP_LAST:     tap_24     = data[TAP_W-1:0];
        default: ;
      endcase
    endfunction

    // Advance line stores and window by one pixel, queue a result if in range
    function void take_pixel(logic [PIX_W-1:0] p);
      int unsigned      w, h, col, row, s;
      int unsigned      r, c, k;
      logic [PIX_W-1:0] above [KM1];
      longint           acc;
      conv_result_t     res;
      w   = line_width();
      h   = frame_rows();
      col = (col_cnt >= w) ? 0 : col_cnt;
      row = (row_cnt >= h) ? 0 : row_cnt;

      for (r = 0; r < KM1; r++) above[r] = line_mem[r][col];
      for (r = 0; r + 1 < KM1; r++) line_mem[r][col] = above[r+1];
      line_mem[KM1-1][col] = p;

      for (r = 0; r < KSIZE; r++)
        for (c = 0; c < KM1; c++) win[r][c] = win[r][c+1];
      for (r = 0; r < KM1; r++) win[r][KM1] = above[r];
      win[KM1][KM1] = p;

      if (w >= KSIZE && h >= KSIZE && row >= KM1 && col >= KM1) begin
        s   = shift_reg;
        acc = 0;
        for (k = 0; k < KSIZE*KSIZE; k++)
          acc += longint'(win[k/KSIZE][k%KSIZE]) * tap_at(k);
        // half-LSB bias, then floor shift
        if (s > 0) acc += longint'(1) << (s - 1);
        acc       = acc >>> s;
        res.value = acc[OUT_W-1:0];
        res.last  = (row == h - 1) && (col == w - 1);
        expected_results.push_back(res);
      end

      if (col + 1 >= w) begin
        col_cnt = 0;
        row_cnt = (row + 1 >= h) ? 0 : row + 1;
      end else begin
        col_cnt = col + 1;
        row_cnt = row;
      end
    endfunction

    function bit count_failure();
      failures++;
      return failures <= MAX_REPORTS;
    endfunction

    function void check_output(logic signed [OUT_W-1:0] value, logic last);
      conv_result_t want;
      if (expected_results.size() == 0) begin
        if (count_failure())
          $error("filtered_value: expected nothing, got %0d", $signed(value));
        return;
      end
      want = expected_results.pop_front();
      if (value !== want.value && count_failure())
        $error("filtered_value: expected %0d, got %0d", $signed(want.value), $signed(value));
      if (last !== want.last && count_failure())
        $error("frame_last: expected %0b, got %0b", want.last, last);
    endfunction
  endclass

  logic clk;
  logic rst;

  lbc_pixel_if  pix_ch();
  lbc_result_if res_ch();
  lbc_cfg_if    cfg_ch();

  conv_scoreboard sb = new();

  bit          src_idle_on = 1'b1;
  bit          snk_idle_on = 1'b1;
  int unsigned hold_request = 0;
  int unsigned live_pixels = 0;
  pixel_mode_t pixel_mode = PIX_UNIFORM;

  line_buffer_2d_convolution_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .pixels  (pix_ch),
    .results (res_ch),
    .cfg     (cfg_ch)
  );

  // 50 MHz clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("** line_buffer_2d_convolution_unit: FAILED **");
    $finish;
  end

  // Result side: check each transaction, drive ready with random stalls and hold-offs
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready)
        sb.check_output(res_ch.filtered_value, res_ch.frame_last);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= !(snk_idle_on && $urandom_range(99) < 17);
      end
    end
  end

  function automatic logic [PIX_W-1:0] next_pixel();
    case (pixel_mode)
      PIX_EXTREME:    return $urandom_range(1) ? 8'hFF : 8'h00;
      PIX_NEAR_RAILS: return $urandom_range(1) ? PIX_W'($urandom_range(255, 224)) :
                                                 PIX_W'($urandom_range(31));
      default:        return PIX_W'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] tap_word(tap_style_t style);
    logic [WORD_W-1:0] word;
    int unsigned       i;
    case (style)
      TAPS_MAX: word = {8{8'h7F}};
      TAPS_MIN: word = {8{8'h80}};
      TAPS_SMALL: begin
        for (i = 0; i < 8; i++) word[8*i +: 8] = 8'($urandom_range(6) - 3);
      end
      default: word = {$urandom, $urandom};
    endcase
    return word;
  endfunction

  // Config transaction; valid stays high for a following write
  task automatic write_reg(input logic [ADDR_W-1:0] idx, input logic [WORD_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.set_register(idx, data);
  endtask

  // Pixel transaction with random source gaps; valid stays high afterwards
  task automatic send_pixel(input logic [PIX_W-1:0] p);
    while (src_idle_on && $urandom_range(99) < 17) begin
      pix_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pix_ch.valid    <= 1'b1;
    pix_ch.pixel_in <= p;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    if (sb.makes_results()) live_pixels++;
    sb.take_pixel(p);
  endtask

  // Pixels until the frame counters wrap back to the origin
  task automatic send_frame();
    do send_pixel(next_pixel()); while (!sb.at_frame_start());
  endtask

  // Stop the source, wait for all results, then let the pipe settle
  task automatic drain();
    pix_ch.valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random register update; only called while the block is idle
  task automatic reconfigure(input shape_mode_t shape);
    logic [DIM_W-1:0]   w_new, h_new;
    logic [WORD_W-1:0]  noise;
    logic [SHIFT_W-1:0] shift_new;
    tap_style_t         style;
    int unsigned        pick;
    w_new = sb.width_reg;
    h_new = sb.height_reg;
    case (shape)
      SHAPE_RANDOM: begin
        pick  = $urandom_range(99);
        w_new = DIM_W'((pick < 75) ? $urandom_range(12, 3) :
                       (pick < 85) ? $urandom_range(2, 0) : $urandom_range(40, 13));
        pick  = $urandom_range(99);
        h_new = DIM_W'((pick < 80) ? $urandom_range(6, 3) :
                       (pick < 90) ? $urandom_range(2, 0) : $urandom_range(12, 7));
      end
      // smaller bounds mid-frame only touch columns already stored
      SHAPE_SHRINK: begin
        w_new = DIM_W'($urandom_range(sb.line_width(), 1));
        h_new = DIM_W'($urandom_range(sb.frame_rows(), 1));
      end
      SHAPE_PRESSURE: begin
        w_new = DIM_W'($urandom_range(24, 16));
        h_new = DIM_W'($urandom_range(6, 4));
      end
      default: ;
    endcase
    if (shape != SHAPE_KEEP) begin
      noise = {$urandom, $urandom};
      noise[DIM_W-1:0] = w_new;
      write_reg(REG_FRAME_WIDTH, noise);
      noise = {$urandom, $urandom};
      noise[DIM_W-1:0] = h_new;
      write_reg(REG_FRAME_HEIGHT, noise);
    end

    if ($urandom_range(99) < 50) begin
      pick      = $urandom_range(99);
      shift_new = SHIFT_W'((pick < 25) ? 0 : (pick < 40) ? 20 : (pick < 50) ? 31 :
                           $urandom_range(12, 1));
      noise     = {$urandom, $urandom};
      noise[SHIFT_W-1:0] = shift_new;
      write_reg(REG_SHIFT_AMOUNT, noise);
    end

    if ($urandom_range(99) < 60) begin
      pick  = $urandom_range(99);
      style = (pick < 70) ? TAPS_RANDOM : (pick < 80) ? TAPS_MAX :
              (pick < 90) ? TAPS_MIN : TAPS_SMALL;
      write_reg(REG_TAPS_WORD_A, tap_word(style));
      write_reg(REG_TAPS_WORD_B, tap_word(style));
      write_reg(REG_TAPS_WORD_C, tap_word(TAPS_RANDOM));
      if ($urandom_range(99) < 30) write_reg(REG_TAP_LAST, {$urandom, $urandom});
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // One random phase; always ends back at the frame origin with the block idle
  task automatic run_phase(input int unsigned phase_no);
    phase_kind_t kind;
    int unsigned pick, frame_size;
    pick = $urandom_range(99);
    if (phase_no == 0 || pick < 5)        kind = PH_PRESSURE;
    else if (phase_no == 1 || pick < 15) kind = PH_STEADY;
    else if (pick < 35)                   kind = PH_MID_FRAME;
    else                                  kind = PH_FRAMES;

    pick        = $urandom_range(99);
    pixel_mode  = (pick < 70) ? PIX_UNIFORM : (pick < 85) ? PIX_EXTREME : PIX_NEAR_RAILS;
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;

    case (kind)
      // receiver holds off while the sender keeps offering
      PH_PRESSURE: begin
        reconfigure(SHAPE_PRESSURE);
        src_idle_on  = 1'b0;
        hold_request = HOLD_CYCLES;
        send_frame();
      end
      PH_STEADY: begin
        reconfigure(SHAPE_PRESSURE);
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        repeat (2) send_frame();
      end
      // stop part way, shrink the frame and retune, then finish the frame
      PH_MID_FRAME: begin
        reconfigure(SHAPE_RANDOM);
        frame_size = sb.line_width() * sb.frame_rows();
        if (frame_size > 1) begin
          repeat ($urandom_range(frame_size - 1, 1)) send_pixel(next_pixel());
          drain();
          reconfigure(SHAPE_SHRINK);
          while (!sb.at_frame_start()) send_pixel(next_pixel());
        end else begin
          send_frame();
        end
      end
      default: begin
        reconfigure(($urandom_range(99) < 60) ? SHAPE_RANDOM : SHAPE_KEEP);
        repeat ($urandom_range(2, 1)) send_frame();
      end
    endcase
    drain();
  endtask

  // Main sequence
  initial begin : stimulus
    int unsigned phase_no;
    rst             <= 1'b1;
    pix_ch.valid    <= 1'b0;
    pix_ch.pixel_in <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.addr     <= REG_FRAME_WIDTH;
    cfg_ch.data     <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // largest positive sum: all taps +127 on a saturated 3x3 frame
    write_reg(REG_FRAME_WIDTH, WORD_W'(KSIZE));
    write_reg(REG_FRAME_HEIGHT, WORD_W'(KSIZE));
    write_reg(REG_SHIFT_AMOUNT, WORD_W'(0));
    write_reg(REG_TAPS_WORD_A, tap_word(TAPS_MAX));
    write_reg(REG_TAPS_WORD_B, tap_word(TAPS_MAX));
    write_reg(REG_TAPS_WORD_C, tap_word(TAPS_RANDOM));
    write_reg(REG_TAP_LAST, {$urandom, $urandom});
    write_reg(REG_UNMAPPED, {$urandom, $urandom});
    cfg_ch.valid <= 1'b0;
    repeat (KSIZE*KSIZE) send_pixel(8'hFF);
    drain();

    // most negative sum: all taps -128
    write_reg(REG_TAPS_WORD_A, tap_word(TAPS_MIN));
    write_reg(REG_TAPS_WORD_B, tap_word(TAPS_MIN));
    cfg_ch.valid <= 1'b0;
    repeat (KSIZE*KSIZE) send_pixel(8'hFF);
    drain();

    // zero width acts as one; frame too narrow gives no result
    write_reg(REG_FRAME_WIDTH, WORD_W'(0));
    write_reg(REG_FRAME_HEIGHT, WORD_W'(2));
    cfg_ch.valid <= 1'b0;
    send_pixel(8'h00);
    send_pixel(8'hFF);
    drain();

    // zero height acts as one
    write_reg(REG_FRAME_WIDTH, WORD_W'(2));
    write_reg(REG_FRAME_HEIGHT, WORD_W'(0));
    cfg_ch.valid <= 1'b0;
    send_pixel(8'hFF);
    send_pixel(8'h00);
    drain();

    // random phases
    live_pixels = 0;
    phase_no    = 0;
    while (live_pixels < RANDOM_ITEMS) begin
      run_phase(phase_no);
      phase_no++;
    end

    // oversize width and height, then shrink mid-row so the column wraps to zero
    pixel_mode  = PIX_UNIFORM;
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    write_reg(REG_FRAME_WIDTH, WORD_W'(11'h7FF));
    write_reg(REG_FRAME_HEIGHT, WORD_W'(11'h7FF));
    write_reg(REG_TAPS_WORD_A, tap_word(TAPS_RANDOM));
    write_reg(REG_TAPS_WORD_B, tap_word(TAPS_RANDOM));
    cfg_ch.valid <= 1'b0;
    repeat (2*KSIZE) send_pixel(next_pixel());
    drain();
    write_reg(REG_FRAME_WIDTH, WORD_W'(KSIZE));
    write_reg(REG_FRAME_HEIGHT, WORD_W'(KSIZE));
    cfg_ch.valid <= 1'b0;
    while (!sb.at_frame_start()) send_pixel(next_pixel());
    drain();

    if (sb.failures == 0 && sb.expected_results.size() == 0) begin
      $display("** line_buffer_2d_convolution_unit: PASSED **");
    end else begin
      $display("** line_buffer_2d_convolution_unit: FAILED **");
    end
    $finish;
  end

endmodule
